/* rtl/hcsd_pkg.sv */
// ----------------------------------------------------------------------------
// hcsd_pkg
// Shared types, constants and six-step tables for the hall commutation,
// speed and duty unit.
// ----------------------------------------------------------------------------
package hcsd_pkg;

    localparam int unsigned HallW  = 3;
    localparam int unsigned CountW = 16;
    localparam int unsigned GainW  = 8;
    localparam int unsigned DutyW  = 10;
    localparam int unsigned MaskW  = 6;
    localparam int unsigned LowW   = 8;
    localparam int unsigned EntryW = 6;

    localparam logic [CountW-1:0] COUNT_ORIGIN   = 16'h8000;
    localparam logic [GainW-1:0]  GAIN_RESET     = 8'd25;
    localparam logic [EntryW-1:0] HIGH_SIDE_BITS = 6'b111000;
    localparam logic [EntryW-1:0] LOW_SIDE_BITS  = 6'b000111;
    localparam logic [1:0]        DUTY_HIGH_MAX  = 2'h3;

    // Input word
    typedef struct packed {
        logic [HallW-1:0]  hall_code;
        logic              tick;
        logic [CountW-1:0] position_count;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [MaskW-1:0]  high_side_mask;
        logic [LowW-1:0]   low_side_value;
        logic [DutyW-1:0]  duty;
        logic              direction_out;
        logic [CountW-1:0] speed_magnitude;
    } t_out_word;

    // Outcome of one timer sample
    typedef struct packed {
        logic              direction;
        logic [CountW-1:0] magnitude;
        logic [DutyW-1:0]  duty;
    } t_sample;

    // Forward six-step table, indexed by hall code
    function automatic logic [EntryW-1:0] drive_fwd(input logic [HallW-1:0] hall);
        logic [EntryW-1:0] entry;
        case (hall)
            3'd1:    entry = 6'h0A;
            3'd2:    entry = 6'h14;
            3'd3:    entry = 6'h0C;
            3'd4:    entry = 6'h21;
            3'd5:    entry = 6'h22;
            3'd6:    entry = 6'h11;
            default: entry = 6'h00;
        endcase
        return entry;
    endfunction

    // Reverse six-step table, indexed by hall code
    function automatic logic [EntryW-1:0] drive_rev(input logic [HallW-1:0] hall);
        logic [EntryW-1:0] entry;
        case (hall)
            3'd1:    entry = 6'h21;
            3'd2:    entry = 6'h0A;
            3'd3:    entry = 6'h22;
            3'd4:    entry = 6'h14;
            3'd5:    entry = 6'h11;
            3'd6:    entry = 6'h0C;
            default: entry = 6'h00;
        endcase
        return entry;
    endfunction

endpackage

/* rtl/hcsd_speed.sv */
// ----------------------------------------------------------------------------
// hcsd_speed
// Turns a position count sample into direction, speed magnitude and duty.
// ----------------------------------------------------------------------------
module hcsd_speed (
    input  logic [hcsd_pkg::CountW-1:0] i_count,
    input  logic [hcsd_pkg::GainW-1:0]  i_gain,
    output hcsd_pkg::t_sample           o_sample
);
    import hcsd_pkg::*;

    logic                      direction;
    logic [CountW-1:0]         magnitude;
    logic [CountW+GainW-1:0]   product;
    logic [7:0]                prod_hi;
    logic [7:0]                prod_lo;
    logic [1:0]                hi_clamped;

    // Split count around the restart value into sign and magnitude
    always_comb begin
        direction = (i_count > COUNT_ORIGIN);
        if (direction) begin
            magnitude = i_count - COUNT_ORIGIN;
        end else begin
            magnitude = COUNT_ORIGIN - i_count;
        end
    end

    // Scale by gain, keep the low 16 bits, saturate the high byte
    always_comb begin
        product    = magnitude * i_gain;
        prod_hi    = product[15:8];
        prod_lo    = product[7:0];
        hi_clamped = (prod_hi > 8'(DUTY_HIGH_MAX)) ? DUTY_HIGH_MAX : prod_hi[1:0];
    end

    assign o_sample.direction = direction;
    assign o_sample.magnitude = magnitude;
    assign o_sample.duty      = {DUTY_HIGH_MAX - hi_clamped, 8'hFF - prod_lo};

endmodule

/* rtl/hcsd_commute.sv */
// ----------------------------------------------------------------------------
// hcsd_commute
// Six-step lookup: hall code and direction to high-side mask and low byte.
// ----------------------------------------------------------------------------
module hcsd_commute (
    input  logic [hcsd_pkg::HallW-1:0] i_hall,
    input  logic                       i_direction,
    output logic [hcsd_pkg::MaskW-1:0] o_high_mask,
    output logic [hcsd_pkg::LowW-1:0]  o_low_value
);
    import hcsd_pkg::*;

    logic [EntryW-1:0] entry;

    // Pick the table by direction
    assign entry = i_direction ? drive_rev(i_hall) : drive_fwd(i_hall);

    // High side keeps bits 5..3; low side is the inverted low three enable bits
    assign o_high_mask = entry & HIGH_SIDE_BITS;
    assign o_low_value = ~{2'b00, (entry & LOW_SIDE_BITS)};

endmodule

/* rtl/hall_commutation_speed_duty_unit.sv */
// ----------------------------------------------------------------------------
// hall_commutation_speed_duty_unit
// Six-step hall commutation with speed measurement and speed-derived duty.
// ----------------------------------------------------------------------------
// One word is accepted per clock and one result word leaves per clock when
// the output side keeps i_ready high. A word is captured in the input
// register, then the sign/magnitude split, the 16x8 gain multiply with
// duty clamp and the six-step lookup run combinationally into the result
// register. Stored direction, speed and duty take a ticked word's sample as
// it moves into the result register, so words see them in arrival order.
// The gain register is written by i_cfg_we / i_cfg_wdata and resets to 25.
module hall_commutation_speed_duty_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  hcsd_pkg::t_in_word         i_item,
    output logic                       o_valid,
    input  logic                       i_ready,
    output hcsd_pkg::t_out_word        o_result,
    input  logic                       i_cfg_we,
    input  logic [hcsd_pkg::GainW-1:0] i_cfg_wdata
);
    import hcsd_pkg::*;

    logic              r_s1_valid;
    t_in_word          r_s1_item;
    logic              r_o_valid;
    t_out_word         r_o_result;
    logic [GainW-1:0]  r_gain;
    logic              r_dir;
    logic [CountW-1:0] r_speed;
    logic [DutyW-1:0]  r_duty;

    logic              n_dir;
    logic [CountW-1:0] n_speed;
    logic [DutyW-1:0]  n_duty;
    logic              advance;
    t_sample           sample;
    logic [MaskW-1:0]  high_mask;
    logic [LowW-1:0]   low_value;

    // Move a word forward when the result slot is free or being drained
    assign advance = r_s1_valid && (!r_o_valid || i_ready);
    assign o_ready = !r_s1_valid || advance;

    hcsd_speed u_speed (
        .i_count  (r_s1_item.position_count),
        .i_gain   (r_gain),
        .o_sample (sample)
    );

    // Take the new sample on a tick, else hold the stored values
    always_comb begin
        if (r_s1_item.tick) begin
            n_dir   = sample.direction;
            n_speed = sample.magnitude;
            n_duty  = sample.duty;
        end else begin
            n_dir   = r_dir;
            n_speed = r_speed;
            n_duty  = r_duty;
        end
    end

    hcsd_commute u_commute (
        .i_hall      (r_s1_item.hall_code),
        .i_direction (n_dir),
        .o_high_mask (high_mask),
        .o_low_value (low_value)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_s1_item <= i_item;
        end
    end

    // Result register and stored motion state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_dir     <= 1'b0;
            r_speed   <= '0;
            r_duty    <= '0;
        end else begin
            if (advance) begin
                r_o_valid <= 1'b1;
                r_dir     <= n_dir;
                r_speed   <= n_speed;
                r_duty    <= n_duty;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
        if (advance) begin
            r_o_result.high_side_mask  <= high_mask;
            r_o_result.low_side_value  <= low_value;
            r_o_result.duty            <= n_duty;
            r_o_result.direction_out   <= n_dir;
            r_o_result.speed_magnitude <= n_speed;
        end
    end

    // Gain register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (i_cfg_we) begin
            r_gain <= i_cfg_wdata;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_result = r_o_result;

endmodule

/* rtl/hcsd_checker.sv */
// ----------------------------------------------------------------------------
// hcsd_checker
// Port-level checks for the hall commutation unit, bound to the top level.
// ----------------------------------------------------------------------------
module hcsd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_ready,
    input hcsd_pkg::t_out_word o_result
);
    import hcsd_pkg::*;

    // Hold a stalled result word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result))
        else $error("result word changed while stalled");

    // Drop output valid after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Drive at most one high-side switch, and none exactly when low side is off
    a_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot0(o_result.high_side_mask)
            && ((o_result.high_side_mask == '0) == (o_result.low_side_value == 8'hFF))
            && (o_result.low_side_value[7:3] == 5'b11111))
        else $error("illegal commutation pattern");

    // Speed never exceeds the half range, zero speed gives idle or full duty
    a_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.speed_magnitude <= COUNT_ORIGIN)
            && (o_result.speed_magnitude != '0
                || o_result.duty == '0 || o_result.duty == 10'h3FF))
        else $error("speed or duty out of range");

endmodule

bind hall_commutation_speed_duty_unit hcsd_checker u_hcsd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_result (o_result)
);
